/* rtl/core/crc16pd_pkg.sv */
// shared types, constants and crc function for the crc16 packet deframer
`default_nettype none
package crc16pd_pkg;

   localparam int MAGIC_BYTES = 4;
   localparam int HEADER_TAIL_BYTES = 30;
   localparam int POS_W = 17;
   localparam int RSPQ_DEPTH = 4;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_WORD       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VERSION = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD      = 2'd2;

   localparam logic [31:0] MAGIC_WORD_RESET       = 32'h0000_0000;
   localparam logic [7:0]  EXPECTED_VERSION_RESET = 8'd1;
   localparam logic [15:0] MAX_PAYLOAD_RESET      = 16'd256;

   // frame status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd1;
   localparam logic [2:0] STATUS_MAGIC     = 3'd2;
   localparam logic [2:0] STATUS_VERSION   = 3'd3;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd4;
   localparam logic [2:0] STATUS_CRC       = 3'd5;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic        last;
      logic [2:0]  status;
      logic [7:0]  packet_type;
      logic [7:0]  flag_bits;
      logic [7:0]  reserved_byte;
      logic [15:0] payload_length;
      logic [31:0] sequence_res;
      logic [31:0] created_ms;
      logic [63:0] source_identity;
      logic [63:0] destination_identity;
   } rsp_type;

   typedef struct packed {
      logic [31:0] magic_word;
      logic [7:0]  expected_version;
      logic [15:0] max_payload;
   } cfg_type;

   // results of one accepted byte, in delivery order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   // msb-first crc-16, one byte folded in
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/crc16pd_csr.sv */
// configuration registers of the deframer
`default_nettype none
module crc16pd_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [crc16pd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                         csr_write_data,
   output crc16pd_pkg::cfg_type                     cfg
);

   crc16pd_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            crc16pd_pkg::CSR_MAGIC_WORD: begin
               cfg_in.magic_word = csr_write_data;
            end
            crc16pd_pkg::CSR_EXPECTED_VERSION: begin
               cfg_in.expected_version = csr_write_data[7:0];
            end
            crc16pd_pkg::CSR_MAX_PAYLOAD: begin
               cfg_in.max_payload = csr_write_data[15:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word       <= crc16pd_pkg::MAGIC_WORD_RESET;
         cfg_ff.expected_version <= crc16pd_pkg::EXPECTED_VERSION_RESET;
         cfg_ff.max_payload      <= crc16pd_pkg::MAX_PAYLOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* rtl/core/crc16pd_parse.sv */
// frame parser: header capture, crc, payload streaming and summary status per frame
`default_nettype none
module crc16pd_parse #(
   parameter int MAGIC_BYTES = crc16pd_pkg::MAGIC_BYTES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire crc16pd_pkg::req_type beat,
   input  wire crc16pd_pkg::cfg_type cfg,
   output crc16pd_pkg::push_type     push
);

   localparam int POS_W = crc16pd_pkg::POS_W;
   localparam int HEADER_BYTES = MAGIC_BYTES + crc16pd_pkg::HEADER_TAIL_BYTES;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic             skipping_ff, skipping_in;
   logic [15:0]      length_ff, length_in;
   logic [23:0]      tfr_ff, tfr_in;
   logic [63:0]      seq_time_ff, seq_time_in;
   logic [63:0]      src_ff, src_in;
   logic [63:0]      dst_ff, dst_in;

   logic [POS_W-1:0] hdr_full;
   logic [4:0]       hdr_idx;
   logic [4:0]       seq_off, src_off, dst_off;
   logic [1:0]       tfr_lane;
   logic [POS_W-1:0] payload_end;
   logic             in_magic, in_header, in_payload, at_crc_lo;
   logic [15:0]      crc_byte;
   logic [7:0]       magic_byte;
   logic             hit;
   logic [2:0]       status;
   logic             payload_out;
   logic             clear;
   crc16pd_pkg::rsp_type summary;
   crc16pd_pkg::rsp_type payload;

   assign hdr_full    = pos_ff - POS_W'(MAGIC_BYTES);
   assign hdr_idx     = hdr_full[4:0];
   assign seq_off     = hdr_idx - 5'd6;
   assign src_off     = hdr_idx - 5'd14;
   assign dst_off     = hdr_idx - 5'd22;
   assign tfr_lane    = hdr_idx[1:0] - 2'd1;
   assign payload_end = POS_W'(HEADER_BYTES) + {{(POS_W-16){1'b0}}, length_ff};
   assign in_magic    = pos_ff < POS_W'(MAGIC_BYTES);
   assign in_header   = pos_ff < POS_W'(HEADER_BYTES);
   assign in_payload  = pos_ff < payload_end;
   assign at_crc_lo   = pos_ff == payload_end;
   assign crc_byte    = crc16pd_pkg::crc16_byte(crc_ff, beat.data_byte);
   assign magic_byte  = cfg.magic_word[{pos_ff[1:0], 3'b000} +: 8];

   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      crc_lo_in   = crc_lo_ff;
      skipping_in = skipping_ff;
      length_in   = length_ff;
      tfr_in      = tfr_ff;
      seq_time_in = seq_time_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      hit         = 1'b0;
      status      = crc16pd_pkg::STATUS_OK;
      payload_out = 1'b0;
      clear       = 1'b0;
      push        = '0;
      summary     = '0;
      payload     = '0;

      if (accept) begin
         if (skipping_ff) begin
            clear = beat.end_of_buffer;
         end else begin
            if (in_magic) begin
               crc_in = crc_byte;
               if (beat.data_byte != magic_byte) begin
                  hit    = 1'b1;
                  status = crc16pd_pkg::STATUS_MAGIC;
               end
            end else if (in_header) begin
               crc_in = crc_byte;
               if (hdr_idx == 5'd0) begin
                  if (beat.data_byte != cfg.expected_version) begin
                     hit    = 1'b1;
                     status = crc16pd_pkg::STATUS_VERSION;
                  end
               end else if (hdr_idx inside {[5'd1:5'd3]}) begin
                  tfr_in[{tfr_lane, 3'b000} +: 8] = beat.data_byte;
               end else if (hdr_idx == 5'd4) begin
                  length_in[7:0] = beat.data_byte;
               end else if (hdr_idx == 5'd5) begin
                  length_in[15:8] = beat.data_byte;
                  if ({beat.data_byte, length_ff[7:0]} > cfg.max_payload) begin
                     hit    = 1'b1;
                     status = crc16pd_pkg::STATUS_TOO_LONG;
                  end
               end else if (hdr_idx inside {[5'd6:5'd13]}) begin
                  seq_time_in[{seq_off[2:0], 3'b000} +: 8] = beat.data_byte;
               end else if (hdr_idx inside {[5'd14:5'd21]}) begin
                  src_in[{src_off[2:0], 3'b000} +: 8] = beat.data_byte;
               end else begin
                  dst_in[{dst_off[2:0], 3'b000} +: 8] = beat.data_byte;
               end
            end else if (in_payload) begin
               crc_in      = crc_byte;
               payload_out = 1'b1;
            end else if (at_crc_lo) begin
               crc_lo_in = beat.data_byte;
            end else begin
               hit    = 1'b1;
               status = ({beat.data_byte, crc_lo_ff} == crc_ff) ?
                        crc16pd_pkg::STATUS_OK : crc16pd_pkg::STATUS_CRC;
            end

            pos_in = pos_ff + POS_W'(1);

            if (!hit && beat.end_of_buffer) begin
               hit    = 1'b1;
               status = crc16pd_pkg::STATUS_TRUNCATED;
            end

            payload.kind         = crc16pd_pkg::KIND_PAYLOAD;
            payload.payload_byte = beat.data_byte;
            payload.last         = !hit;

            summary.kind                 = crc16pd_pkg::KIND_SUMMARY;
            summary.last                 = 1'b1;
            summary.status               = status;
            summary.packet_type          = tfr_in[7:0];
            summary.flag_bits            = tfr_in[15:8];
            summary.reserved_byte        = tfr_in[23:16];
            summary.payload_length       = length_in;
            summary.sequence_res         = seq_time_in[31:0];
            summary.created_ms           = seq_time_in[63:32];
            summary.source_identity      = src_in;
            summary.destination_identity = dst_in;

            if (payload_out) begin
               push.first  = payload;
               push.second = summary;
               push.count  = hit ? 2'd2 : 2'd1;
            end else begin
               push.first = summary;
               push.count = hit ? 2'd1 : 2'd0;
            end

            if (hit && !beat.end_of_buffer) begin
               skipping_in = 1'b1;
            end
            clear = beat.end_of_buffer;
         end
      end

      // end of buffer: next byte opens a new buffer
      if (clear) begin
         pos_in      = '0;
         crc_in      = crc16pd_pkg::CRC_INIT;
         crc_lo_in   = '0;
         skipping_in = 1'b0;
         length_in   = '0;
         tfr_in      = '0;
         seq_time_in = '0;
         src_in      = '0;
         dst_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         crc_ff      <= crc16pd_pkg::CRC_INIT;
         crc_lo_ff   <= '0;
         skipping_ff <= 1'b0;
         length_ff   <= '0;
         tfr_ff      <= '0;
         seq_time_ff <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
      end else begin
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         crc_lo_ff   <= crc_lo_in;
         skipping_ff <= skipping_in;
         length_ff   <= length_in;
         tfr_ff      <= tfr_in;
         seq_time_ff <= seq_time_in;
         src_ff      <= src_in;
         dst_ff      <= dst_in;
      end
   end

   // a skipped buffer end restarts the parser
   assert property (@(posedge clock) disable iff (reset)
      accept && skipping_ff && beat.end_of_buffer |=> pos_ff == '0 && !skipping_ff)
      else $error("parser did not restart after skipped buffer end");

   // two results from one byte are always a payload byte then the summary
   assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.first.kind && push.second.kind && push.second.last)
      else $error("bad result pair order");

endmodule
`default_nettype wire

/* rtl/core/crc16pd_rspq.sv */
// result queue: holds up to two results per byte and parts the two handshakes
`default_nettype none
module crc16pd_rspq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire crc16pd_pkg::push_type push,
   output logic                       full,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output crc16pd_pkg::rsp_type       rsp_data
);

   localparam int DEPTH = crc16pd_pkg::RSPQ_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   crc16pd_pkg::rsp_type entry_ff [DEPTH];
   crc16pd_pkg::rsp_type entry_in [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] tail_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign tail_next = tail_ff + PTR_W'(1);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[head_ff];
   // room for a full pair is judged on the registered count
   assign full      = count_ff > CNT_W'(DEPTH - 2);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
         if (push.count != 2'd0 && tail_ff == PTR_W'(i)) begin
            entry_in[i] = push.first;
         end
         if (push.count == 2'd2 && tail_next == PTR_W'(i)) begin
            entry_in[i] = push.second;
         end
      end
      tail_in  = tail_ff + PTR_W'(push.count);
      head_in  = pop ? head_ff + PTR_W'(1) : head_ff;
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= CNT_W'(DEPTH - 2))
      else $error("push without room for a pair");

   assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd0 && !pop |=> count_ff == $past(count_ff) && head_ff == $past(head_ff))
      else $error("queue moved without push or pop");

endmodule
`default_nettype wire

/* rtl/core/crc16_packet_deframer_top.sv */
// top level of the crc16 packet deframer
//
//   port group   dir   carries
//   req_*        in    one received byte per beat with end-of-buffer flag
//   rsp_*        out   payload byte results and one summary per frame
//   csr_*        in    magic word, expected version, payload length limit
//
// a byte is taken every cycle while the queue has room; its results enter the queue at the same edge
// and leave at one per cycle from the next while rsp_stall is low; a pair of results leaves one after the other
// the four-entry result queue stalls req when fewer than two entries are free
// synchronous reset clears parser state and restores register defaults
// rsp_stall only holds the queue; bytes keep flowing until it fills
`default_nettype none
module crc16_packet_deframer_top #(
   parameter int MAGIC_BYTES = crc16pd_pkg::MAGIC_BYTES
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire crc16pd_pkg::req_type                req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output crc16pd_pkg::rsp_type                     rsp_data,
   input  wire logic                                csr_write_en,
   input  wire logic [crc16pd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                         csr_write_data
);

   crc16pd_pkg::cfg_type  cfg;
   crc16pd_pkg::push_type push;
   logic                  full;
   logic                  accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   crc16pd_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   crc16pd_parse #(
      .MAGIC_BYTES (MAGIC_BYTES)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .beat   (req_data),
      .cfg    (cfg),
      .push   (push)
   );

   crc16pd_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* tb/sv/crc16_packet_deframer_checker.sv */
// result checker for the crc16 packet deframer: predicts every result beat and compares
`timescale 1ns / 100ps
module crc16_packet_deframer_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  crc16pd_pkg::req_type                req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  crc16pd_pkg::rsp_type                rsp_data,
   input  logic                                csr_write_en,
   input  logic [crc16pd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                         csr_write_data,
   output int                                  error_count,
   output int                                  pending_count
);
   import crc16pd_pkg::*;

   localparam int HDR_BYTES = MAGIC_BYTES + HEADER_TAIL_BYTES;

   // register copies
   logic [31:0] cfg_magic;
   logic [7:0]  cfg_version;
   logic [15:0] cfg_max;

   // parser state of the current buffer
   logic [16:0] m_pos;
   logic [15:0] m_crc;
   logic        m_skip;
   logic [15:0] m_len;
   logic [23:0] m_tfr;
   logic [63:0] m_seq_time;
   logic [63:0] m_src;
   logic [63:0] m_dst;
   logic [15:0] m_rx_crc;

   rsp_type pending_results[$];
   int      fail_total = 0;

   // one byte into the running crc, bit by bit from the msb
   function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ 16'h1021;
         end
      end
      return c;
   endfunction

   task automatic clear_frame();
      m_pos = '0;
      m_crc = CRC_INIT;
      m_skip = 1'b0;
      m_len = '0;
      m_tfr = '0;
      m_seq_time = '0;
      m_src = '0;
      m_dst = '0;
      m_rx_crc = '0;
   endtask

   function automatic rsp_type frame_summary(input logic [2:0] code);
      rsp_type r;
      r = '0;
      r.kind = KIND_SUMMARY;
      r.status = code;
      r.packet_type = m_tfr[7:0];
      r.flag_bits = m_tfr[15:8];
      r.reserved_byte = m_tfr[23:16];
      r.payload_length = m_len;
      r.sequence_res = m_seq_time[31:0];
      r.created_ms = m_seq_time[63:32];
      r.source_identity = m_src;
      r.destination_identity = m_dst;
      return r;
   endfunction

   // advance the parser by one byte and queue the results it causes
   task automatic deframe_byte(input logic [7:0] b, input logic eob);
      rsp_type     r0;
      rsp_type     r1;
      int          n;
      int          p;
      int          h;
      logic        done;
      logic [2:0]  code;
      r0 = '0;
      r1 = '0;
      n = 0;
      done = 1'b0;
      code = STATUS_OK;
      if (m_skip) begin
         if (eob) begin
            clear_frame();
         end
         return;
      end
      p = int'(m_pos);
      if (p < MAGIC_BYTES) begin
         m_crc = crc_fold(m_crc, b);
         if (b != cfg_magic[8*(p%4) +: 8]) begin
            done = 1'b1;
            code = STATUS_MAGIC;
         end
      end else if (p < HDR_BYTES) begin
         h = p - MAGIC_BYTES;
         m_crc = crc_fold(m_crc, b);
         if (h == 0) begin
            if (b != cfg_version) begin
               done = 1'b1;
               code = STATUS_VERSION;
            end
         end else if (h < 4) begin
            m_tfr[8*(h-1) +: 8] = b;
         end else if (h < 6) begin
            m_len[8*(h-4) +: 8] = b;
            if (h == 5 && m_len > cfg_max) begin
               done = 1'b1;
               code = STATUS_TOO_LONG;
            end
         end else if (h < 14) begin
            m_seq_time[8*(h-6) +: 8] = b;
         end else if (h < 22) begin
            m_src[8*(h-14) +: 8] = b;
         end else begin
            m_dst[8*(h-22) +: 8] = b;
         end
      end else if (p < HDR_BYTES + int'(m_len)) begin
         m_crc = crc_fold(m_crc, b);
         r0.kind = KIND_PAYLOAD;
         r0.payload_byte = b;
         n = 1;
      end else if (p == HDR_BYTES + int'(m_len)) begin
         m_rx_crc[7:0] = b;
      end else begin
         m_rx_crc[15:8] = b;
         done = 1'b1;
         code = (m_rx_crc == m_crc) ? STATUS_OK : STATUS_CRC;
      end
      m_pos = m_pos + 17'd1;
      if (!done && eob) begin
         done = 1'b1;
         code = STATUS_TRUNCATED;
      end
      if (done) begin
         if (n == 0) begin
            r0 = frame_summary(code);
         end else begin
            r1 = frame_summary(code);
         end
         n++;
         if (eob) begin
            clear_frame();
         end else begin
            m_skip = 1'b1;
         end
      end else if (eob) begin
         clear_frame();
      end
      if (n == 1) begin
         r0.last = 1'b1;
         pending_results.push_back(r0);
      end else if (n == 2) begin
         r1.last = 1'b1;
         pending_results.push_back(r0);
         pending_results.push_back(r1);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_magic = MAGIC_WORD_RESET;
         cfg_version = EXPECTED_VERSION_RESET;
         cfg_max = MAX_PAYLOAD_RESET;
         clear_frame();
         pending_results.delete();
      end else begin
         // a result beat at this edge always stems from an earlier byte
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result beat: kind %0d status %0d", rsp_data.kind,
                      rsp_data.status);
               fail_total++;
            end else begin
               want = pending_results.pop_front();
               check_field("kind", want.kind, rsp_data.kind);
               check_field("payload_byte", want.payload_byte, rsp_data.payload_byte);
               check_field("last", want.last, rsp_data.last);
               check_field("status", want.status, rsp_data.status);
               check_field("packet_type", want.packet_type, rsp_data.packet_type);
               check_field("flag_bits", want.flag_bits, rsp_data.flag_bits);
               check_field("reserved_byte", want.reserved_byte, rsp_data.reserved_byte);
               check_field("payload_length", want.payload_length, rsp_data.payload_length);
               check_field("sequence_res", want.sequence_res, rsp_data.sequence_res);
               check_field("created_ms", want.created_ms, rsp_data.created_ms);
               check_field("source_identity", want.source_identity,
                           rsp_data.source_identity);
               check_field("destination_identity", want.destination_identity,
                           rsp_data.destination_identity);
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_MAGIC_WORD:       cfg_magic = csr_write_data;
               CSR_EXPECTED_VERSION: cfg_version = csr_write_data[7:0];
               CSR_MAX_PAYLOAD:      cfg_max = csr_write_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            deframe_byte(req_data.data_byte, req_data.end_of_buffer);
         end
      end
      pending_count <= pending_results.size();
      error_count <= fail_total;
   end

endmodule

/* tb/sv/crc16_packet_deframer_top_tb.sv */
// testbench top for the crc16 packet deframer: buffer stimulus, back pressure and verdict
`timescale 1ns / 100ps
module crc16_packet_deframer_top_tb;
   import crc16pd_pkg::*;

   localparam int PHASE_ITEMS  = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_CYCLES  = 8;
   localparam int DRAIN_LIMIT  = 20000;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_MAGIC,
      FRAME_BAD_VERSION,
      FRAME_TOO_LONG,
      FRAME_BAD_CRC,
      FRAME_TRUNCATED,
      FRAME_NOISE
   } frame_kind_e;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]            csr_write_data = '0;

   int error_count;
   int expected_count;

   // stimulus side copy of the registers, used to build frames
   logic [31:0] cur_magic = MAGIC_WORD_RESET;
   logic [7:0]  cur_version = EXPECTED_VERSION_RESET;
   logic [15:0] cur_max = MAX_PAYLOAD_RESET;

   logic [7:0] frame_bytes[$];
   int         burst_left = 0;
   int         sent_count = 0;
   logic       steady_sender = 1'b0;

   // receiver back pressure
   logic hold_go = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_cnt = 0;
   int   stall_mode = 0;
   int   mode_left = 0;
   int   run_left = 0;

   crc16_packet_deframer_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   crc16_packet_deframer_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .error_count    (error_count),
      .pending_count  (expected_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("TEST FAILED");
      $finish;
   end

   // stall pattern: off, random, or runs; one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else if (hold_go && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_cnt <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(50, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: begin
               if (run_left == 0) begin
                  rsp_stall <= ~rsp_stall;
                  run_left <= $urandom_range(1, 8);
               end else begin
                  run_left <= run_left - 1;
               end
            end
         endcase
      end
   end

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // one beat, with bursts and random gaps between them
   task automatic send_byte(input logic [7:0] b, input logic eob);
      int gap;
      if (burst_left == 0) begin
         gap = 0;
         if (!steady_sender && $urandom_range(0, 2) != 0) begin
            gap = $urandom_range(1, 6);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, end_of_buffer: eob};
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic send_buffer();
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
   endtask

   task automatic trim_frame(input int keep);
      while (frame_bytes.size() > keep) begin
         void'(frame_bytes.pop_back());
      end
   endtask

   task automatic build_frame(input frame_kind_e kind, input int plen, input int extra);
      logic [15:0] len_field;
      logic [15:0] crc;
      int          body;
      int          cut;
      int          err_at;
      frame_bytes.delete();
      if (kind == FRAME_NOISE) begin
         repeat ($urandom_range(1, 6)) frame_bytes.push_back(rand_byte());
         return;
      end
      len_field = 16'(plen);
      body = plen;
      err_at = 0;
      if (kind == FRAME_TOO_LONG) begin
         len_field = $urandom_range(0, 1) ? cur_max + 16'd1
                                         : 16'($urandom_range(int'(cur_max) + 1, 65535));
         body = 0;
      end
      if (kind == FRAME_TRUNCATED && $urandom_range(0, 3) == 0) begin
         len_field = 16'($urandom_range(0, int'(cur_max)));
         body = (len_field > 16'd40) ? 40 : int'(len_field);
      end
      for (int i = 0; i < MAGIC_BYTES; i++) begin
         frame_bytes.push_back(cur_magic[8*i +: 8]);
      end
      frame_bytes.push_back(cur_version);
      repeat (3) frame_bytes.push_back(rand_byte());
      frame_bytes.push_back(len_field[7:0]);
      frame_bytes.push_back(len_field[15:8]);
      // sequence, creation time, source and destination identity
      repeat (24) frame_bytes.push_back(rand_byte());
      repeat (body) frame_bytes.push_back(rand_byte());
      crc = CRC_INIT;
      foreach (frame_bytes[i]) begin
         crc = crc16_byte(crc, frame_bytes[i]);
      end
      case (kind)
         FRAME_BAD_MAGIC: begin
            err_at = $urandom_range(0, MAGIC_BYTES - 1);
            frame_bytes[err_at] ^= 8'($urandom_range(1, 255));
         end
         FRAME_BAD_VERSION: begin
            err_at = MAGIC_BYTES;
            frame_bytes[err_at] ^= 8'($urandom_range(1, 255));
         end
         FRAME_TOO_LONG: err_at = MAGIC_BYTES + 5;
         FRAME_BAD_CRC: crc ^= 16'($urandom_range(1, 65535));
         default: ;
      endcase
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
      cut = frame_bytes.size();
      if (kind == FRAME_BAD_MAGIC || kind == FRAME_BAD_VERSION || kind == FRAME_TOO_LONG) begin
         cut = err_at + 1 + $urandom_range(0, 4);
      end else if (kind == FRAME_TRUNCATED) begin
         cut = $urandom_range(1, frame_bytes.size() - 1);
      end
      trim_frame(cut);
      if (kind == FRAME_GOOD || kind == FRAME_BAD_CRC) begin
         repeat (extra) frame_bytes.push_back(rand_byte());
      end
   endtask

   task automatic random_frame();
      int          pick;
      int          lim;
      int          plen;
      frame_kind_e kind;
      pick = $urandom_range(0, 99);
      if (pick < 35) kind = FRAME_GOOD;
      else if (pick < 45) kind = FRAME_BAD_CRC;
      else if (pick < 60) kind = FRAME_TRUNCATED;
      else if (pick < 70) kind = FRAME_BAD_MAGIC;
      else if (pick < 80) kind = FRAME_BAD_VERSION;
      else if (pick < 90) kind = FRAME_TOO_LONG;
      else kind = FRAME_NOISE;
      if (kind == FRAME_TOO_LONG && cur_max == 16'hFFFF) begin
         kind = FRAME_TRUNCATED;
      end
      lim = (cur_max > 16'd12) ? 12 : int'(cur_max);
      if ($urandom_range(0, 7) == 0) begin
         lim = (cur_max > 16'd48) ? 48 : int'(cur_max);
      end
      plen = $urandom_range(0, lim);
      if (cur_max <= 16'd48 && $urandom_range(0, 5) == 0) begin
         plen = int'(cur_max);
      end
      build_frame(kind, plen, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);
      send_buffer();
   endtask

   // sender stops until every predicted result has been taken
   task automatic wait_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] magic, input logic [7:0] version,
                             input logic [15:0] maxp);
      logic [31:0] word;
      wait_results();
      // a byte without results may still be inside the block
      repeat (IDLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= CSR_MAGIC_WORD;
      csr_write_data <= magic;
      @(posedge clock);
      word = $urandom;
      word[7:0] = version;
      csr_index <= CSR_EXPECTED_VERSION;
      csr_write_data <= word;
      @(posedge clock);
      word = $urandom;
      word[15:0] = maxp;
      csr_index <= CSR_MAX_PAYLOAD;
      csr_write_data <= word;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_magic = magic;
      cur_version = version;
      cur_max = maxp;
   endtask

   task automatic run_phase(input int budget);
      int start;
      start = sent_count;
      while (sent_count - start < budget) begin
         random_frame();
         if ($urandom_range(0, 9) == 0) begin
            wait_results();
         end
      end
   endtask

   initial begin
      int drain_guard;
      drain_guard = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed buffers on the reset register values
      build_frame(FRAME_GOOD, 0, 0);
      send_buffer();
      build_frame(FRAME_GOOD, 5, 3);
      send_buffer();
      build_frame(FRAME_BAD_MAGIC, 0, 0);
      send_buffer();
      build_frame(FRAME_BAD_VERSION, 0, 0);
      send_buffer();
      build_frame(FRAME_TOO_LONG, 0, 0);
      send_buffer();
      build_frame(FRAME_BAD_CRC, 2, 0);
      send_buffer();
      // buffer ends on a payload byte: payload beat then truncated summary
      build_frame(FRAME_GOOD, 4, 0);
      trim_frame(frame_bytes.size() - 3);
      send_buffer();
      // buffer ends on the first crc byte
      build_frame(FRAME_GOOD, 2, 0);
      trim_frame(frame_bytes.size() - 1);
      send_buffer();
      // buffer ends inside the header
      build_frame(FRAME_GOOD, 0, 0);
      trim_frame(20);
      send_buffer();
      build_frame(FRAME_NOISE, 0, 0);
      trim_frame(1);
      send_buffer();

      set_config(32'($urandom), 8'($urandom), 16'($urandom_range(0, 64)));
      hold_go <= 1'b1;
      run_phase(PHASE_ITEMS);

      set_config(32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      run_phase(PHASE_ITEMS);

      set_config(32'h0000_0000, 8'h00, 16'h0000);
      run_phase(PHASE_ITEMS);

      steady_sender = 1'b1;
      set_config(32'($urandom), 8'($urandom), 16'($urandom_range(1, 40)));
      run_phase(PHASE_ITEMS);

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0 && drain_guard < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_guard++;
      end
      repeat (IDLE_CYCLES) @(posedge clock);
      if (expected_count != 0) begin
         $error("%0d expected results never arrived", expected_count);
      end
      if (error_count == 0 && expected_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* crc16_packet_deframer_top.f */
rtl/core/crc16pd_pkg.sv
rtl/core/crc16pd_csr.sv
rtl/core/crc16pd_parse.sv
rtl/core/crc16pd_rspq.sv
rtl/core/crc16_packet_deframer_top.sv
tb/sv/crc16_packet_deframer_checker.sv
tb/sv/crc16_packet_deframer_top_tb.sv
